>>> rtl/spdb_pkg.sv
// ----------------------------------------------------------------------------
// spdb_pkg
// Shared types and codes for the switch panel debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package spdb_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned CFG_W  = 16;
   localparam int unsigned POS_W  = 16;
   localparam int unsigned STEP_W = 2;
   localparam int unsigned ADDR_W = 2;

   // item actions
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_RESET  = 2'd2;

   // register indexes
   localparam logic [ADDR_W-1:0] REG_SWITCH_MS  = 2'd0;
   localparam logic [ADDR_W-1:0] REG_STOP_MS    = 2'd1;
   localparam logic [ADDR_W-1:0] REG_STEP_US    = 2'd2;
   localparam logic [ADDR_W-1:0] REG_REVERSE_US = 2'd3;

   // register reset values
   localparam logic [CFG_W-1:0] SWITCH_MS_RST  = 16'd50;
   localparam logic [CFG_W-1:0] STOP_MS_RST    = 16'd20;
   localparam logic [CFG_W-1:0] STEP_US_RST    = 16'd2000;
   localparam logic [CFG_W-1:0] REVERSE_US_RST = 16'd3000;

   // sticky flag bit positions
   localparam int unsigned FLAG_STOP   = 0;
   localparam int unsigned FLAG_ARM    = 1;
   localparam int unsigned FLAG_LIGHTS = 2;
   localparam int unsigned FLAG_BUTTON = 3;

   // step direction codes, two's complement
   localparam logic [STEP_W-1:0] DIR_NONE = 2'b00;
   localparam logic [STEP_W-1:0] DIR_UP   = 2'b01;
   localparam logic [STEP_W-1:0] DIR_DOWN = 2'b11;

   // encoder pin pair reset: both high
   localparam logic [1:0] PAIR_IDLE = 2'b11;

   typedef struct packed {
      logic [1:0]        action;
      logic [TIME_W-1:0] time_ms;
      logic [TIME_W-1:0] time_us;
      logic              arm_level;
      logic              lights_level;
      logic              stop_level;
      logic              button_level;
      logic              clk_level;
      logic              dt_level;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos_cur;
      logic [POS_W-1:0]  pos_nxt;
      logic [STEP_W-1:0] step_cur;
      logic [STEP_W-1:0] step_nxt;
   } enc_status_type;

   typedef struct packed {
      logic stable_cur;
      logic stable_nxt;
      logic changed;
   } deb_status_type;

endpackage

`default_nettype wire

>>> rtl/spdb_debounce.sv
// ----------------------------------------------------------------------------
// spdb_debounce
// Restart-on-change debounce of one switch level, idle level zero.
// ----------------------------------------------------------------------------
`default_nettype none

module spdb_debounce (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        sample,
   input  wire logic                        level,
   input  wire logic [spdb_pkg::TIME_W-1:0] now,
   input  wire logic [spdb_pkg::CFG_W-1:0]  hold_ms,
   output spdb_pkg::deb_status_type         status
);

   logic                        raw_ff, raw_in;
   logic                        stable_ff, stable_in;
   logic [spdb_pkg::TIME_W-1:0] stamp_ff, stamp_in;
   logic [spdb_pkg::TIME_W-1:0] elapsed;
   logic                        changed;

   always_comb begin
      raw_in   = raw_ff;
      stamp_in = stamp_ff;
      // a new raw level restarts the timer
      if (level != raw_ff) begin
         raw_in   = level;
         stamp_in = now;
      end
      elapsed = now - stamp_in;
      changed = (elapsed > {{(spdb_pkg::TIME_W-spdb_pkg::CFG_W){1'b0}}, hold_ms})
                && (level != stable_ff);
      stable_in = changed ? level : stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         stable_ff <= 1'b0;
         stamp_ff  <= '0;
      end else if (sample) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         stamp_ff  <= stamp_in;
      end
   end

   assign status.stable_cur = stable_ff;
   assign status.stable_nxt = stable_in;
   assign status.changed    = changed;

endmodule

`default_nettype wire

>>> rtl/spdb_encoder.sv
// ----------------------------------------------------------------------------
// spdb_encoder
// Rotary clock/data decoder with step gap and reversal gap.
// ----------------------------------------------------------------------------
`default_nettype none

module spdb_encoder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        sample,
   input  wire logic                        clr_step,
   input  wire logic                        clr_count,
   input  wire logic                        clk_level,
   input  wire logic                        dt_level,
   input  wire logic [spdb_pkg::TIME_W-1:0] now,
   input  wire logic [spdb_pkg::CFG_W-1:0]  step_gap,
   input  wire logic [spdb_pkg::CFG_W-1:0]  reverse_gap,
   output spdb_pkg::enc_status_type         status
);

   localparam int unsigned PAD_W = spdb_pkg::TIME_W - spdb_pkg::CFG_W;

   logic [1:0]                  pair_ff, pair_in;
   logic [spdb_pkg::TIME_W-1:0] stamp_ff, stamp_in;
   logic [spdb_pkg::STEP_W-1:0] dir_ff, dir_in;
   logic [spdb_pkg::POS_W-1:0]  count_ff, count_in;
   logic [spdb_pkg::STEP_W-1:0] delta_ff, delta_in;
   logic [spdb_pkg::TIME_W-1:0] gap;
   logic [1:0]                  cur;
   logic [spdb_pkg::STEP_W-1:0] dir;

   always_comb begin
      gap      = now - stamp_ff;
      cur      = {clk_level, dt_level};
      dir      = dt_level ? spdb_pkg::DIR_UP : spdb_pkg::DIR_DOWN;
      pair_in  = pair_ff;
      stamp_in = stamp_ff;
      dir_in   = dir_ff;
      count_in = count_ff;
      delta_in = delta_ff;
      if (gap >= {{PAD_W{1'b0}}, step_gap} && cur != pair_ff) begin
         pair_in = cur;
         // clock falling edge
         if (pair_ff[1] && !cur[1]) begin
            if (!(dir_ff != spdb_pkg::DIR_NONE && dir != dir_ff
                  && gap < {{PAD_W{1'b0}}, reverse_gap})) begin
               count_in = dt_level ? count_ff + 1'b1 : count_ff - 1'b1;
               delta_in = dir;
               dir_in   = dir;
               stamp_in = now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff  <= spdb_pkg::PAIR_IDLE;
         stamp_ff <= '0;
         dir_ff   <= spdb_pkg::DIR_NONE;
         count_ff <= '0;
         delta_ff <= spdb_pkg::DIR_NONE;
      end else if (sample) begin
         pair_ff  <= pair_in;
         stamp_ff <= stamp_in;
         dir_ff   <= dir_in;
         count_ff <= count_in;
         delta_ff <= delta_in;
      end else begin
         if (clr_count) count_ff <= '0;
         if (clr_step)  delta_ff <= spdb_pkg::DIR_NONE;
      end
   end

   assign status.pos_cur  = count_ff;
   assign status.pos_nxt  = count_in;
   assign status.step_cur = delta_ff;
   assign status.step_nxt = delta_in;

endmodule

`default_nettype wire

>>> rtl/switch_panel_debouncer.sv
// ----------------------------------------------------------------------------
// switch_panel_debouncer
// Control panel input conditioner: switch debounce, stop filter, encoder.
// ----------------------------------------------------------------------------
// Takes one item per clock: an accepted item lands in an input register, is
// evaluated by the debounce, stop and encoder compares once the result
// register is free and its snapshot is held in the result register, so both
// registers keep streaming while the result side takes one transaction per
// cycle. A result that is not taken holds the input register and drops
// req_ready until it leaves. Every item returns exactly one result. Registers
// are to be written through the csr port while idle; the block doesn't check.
`default_nettype none

module switch_panel_debouncer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [spdb_pkg::ADDR_W-1:0]  csr_addr,
   input  wire logic [spdb_pkg::CFG_W-1:0]   csr_wdata,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_action,
   input  wire logic [spdb_pkg::TIME_W-1:0]  req_time_ms,
   input  wire logic [spdb_pkg::TIME_W-1:0]  req_time_us,
   input  wire logic                         req_arm_level,
   input  wire logic                         req_lights_level,
   input  wire logic                         req_stop_level,
   input  wire logic                         req_button_level,
   input  wire logic                         req_clk_level,
   input  wire logic                         req_dt_level,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_armed,
   output logic                              rsp_lights_on,
   output logic                              rsp_stop_active,
   output logic                              rsp_button_down,
   output logic signed [spdb_pkg::POS_W-1:0] rsp_position,
   output logic signed [spdb_pkg::STEP_W-1:0] rsp_last_step,
   output logic                              rsp_stop_seen,
   output logic                              rsp_arm_toggled,
   output logic                              rsp_lights_toggled,
   output logic                              rsp_button_hit
);

   localparam int unsigned PAD_W = spdb_pkg::TIME_W - spdb_pkg::CFG_W;

   logic [spdb_pkg::CFG_W-1:0]  switch_ms_ff, stop_ms_ff, step_us_ff, reverse_us_ff;
   spdb_pkg::item_type          item_ff;
   logic                        item_valid_ff;
   logic                        advance;
   logic                        do_sample, do_read, do_reset;
   logic                        stop_raw_ff, stop_raw_in;
   logic [spdb_pkg::TIME_W-1:0] stop_stamp_ff, stop_stamp_in;
   logic [3:0]                  flags_ff, flags_in, flags_nxt;
   spdb_pkg::enc_status_type    enc;
   spdb_pkg::deb_status_type    arm_st, lights_st, button_st;

   // result register
   logic                        rsp_valid_ff;
   logic                        armed_ff, lights_ff, stop_ff, button_ff;
   logic [spdb_pkg::POS_W-1:0]  pos_ff;
   logic [spdb_pkg::STEP_W-1:0] step_ff;
   logic [3:0]                  rflags_ff;
   logic                        armed_in, lights_in, stop_in, button_in;
   logic [spdb_pkg::POS_W-1:0]  pos_in;
   logic [spdb_pkg::STEP_W-1:0] step_in;
   logic [3:0]                  rflags_in;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign do_sample = advance && (item_ff.action == spdb_pkg::ACT_SAMPLE);
   assign do_read   = advance && (item_ff.action == spdb_pkg::ACT_READ);
   assign do_reset  = advance && (item_ff.action == spdb_pkg::ACT_RESET);

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_ms_ff  <= spdb_pkg::SWITCH_MS_RST;
         stop_ms_ff    <= spdb_pkg::STOP_MS_RST;
         step_us_ff    <= spdb_pkg::STEP_US_RST;
         reverse_us_ff <= spdb_pkg::REVERSE_US_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            spdb_pkg::REG_SWITCH_MS:  switch_ms_ff  <= csr_wdata;
            spdb_pkg::REG_STOP_MS:    stop_ms_ff    <= csr_wdata;
            spdb_pkg::REG_STEP_US:    step_us_ff    <= csr_wdata;
            spdb_pkg::REG_REVERSE_US: reverse_us_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.action       <= req_action;
         item_ff.time_ms      <= req_time_ms;
         item_ff.time_us      <= req_time_us;
         item_ff.arm_level    <= req_arm_level;
         item_ff.lights_level <= req_lights_level;
         item_ff.stop_level   <= req_stop_level;
         item_ff.button_level <= req_button_level;
         item_ff.clk_level    <= req_clk_level;
         item_ff.dt_level     <= req_dt_level;
      end
   end

   spdb_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .sample      (do_sample),
      .clr_step    (do_read || do_reset),
      .clr_count   (do_reset),
      .clk_level   (item_ff.clk_level),
      .dt_level    (item_ff.dt_level),
      .now         (item_ff.time_us),
      .step_gap    (step_us_ff),
      .reverse_gap (reverse_us_ff),
      .status      (enc)
   );

   spdb_debounce u_arm (
      .clock   (clock),
      .reset   (reset),
      .sample  (do_sample),
      .level   (item_ff.arm_level),
      .now     (item_ff.time_ms),
      .hold_ms (switch_ms_ff),
      .status  (arm_st)
   );

   spdb_debounce u_lights (
      .clock   (clock),
      .reset   (reset),
      .sample  (do_sample),
      .level   (item_ff.lights_level),
      .now     (item_ff.time_ms),
      .hold_ms (switch_ms_ff),
      .status  (lights_st)
   );

   // button runs inverted so its idle level is zero: stable high means pressed
   spdb_debounce u_button (
      .clock   (clock),
      .reset   (reset),
      .sample  (do_sample),
      .level   (!item_ff.button_level),
      .now     (item_ff.time_ms),
      .hold_ms (switch_ms_ff),
      .status  (button_st)
   );

   always_comb begin
      stop_raw_in   = stop_raw_ff;
      stop_stamp_in = stop_stamp_ff;
      flags_nxt     = flags_ff;
      if (item_ff.stop_level != stop_raw_ff
          && (item_ff.time_ms - stop_stamp_ff) >= {{PAD_W{1'b0}}, stop_ms_ff}) begin
         stop_raw_in   = item_ff.stop_level;
         stop_stamp_in = item_ff.time_ms;
         if (item_ff.stop_level) flags_nxt[spdb_pkg::FLAG_STOP] = 1'b1;
      end
      if (arm_st.changed)    flags_nxt[spdb_pkg::FLAG_ARM]    = 1'b1;
      if (lights_st.changed) flags_nxt[spdb_pkg::FLAG_LIGHTS] = 1'b1;
      if (button_st.changed && button_st.stable_nxt) begin
         flags_nxt[spdb_pkg::FLAG_BUTTON] = 1'b1;
      end

      flags_in = flags_ff;
      if (do_sample)    flags_in = flags_nxt;
      else if (do_read) flags_in = '0;

      // snapshot: after the update for samples, before the clear for reads; resets show cleared position and step
      armed_in  = arm_st.stable_cur;
      lights_in = lights_st.stable_cur;
      stop_in   = stop_raw_ff;
      button_in = button_st.stable_cur;
      pos_in    = enc.pos_cur;
      step_in   = enc.step_cur;
      rflags_in = flags_ff;
      unique case (item_ff.action)
         spdb_pkg::ACT_SAMPLE: begin
            armed_in  = arm_st.stable_nxt;
            lights_in = lights_st.stable_nxt;
            stop_in   = stop_raw_in;
            button_in = button_st.stable_nxt;
            pos_in    = enc.pos_nxt;
            step_in   = enc.step_nxt;
            rflags_in = flags_nxt;
         end
         spdb_pkg::ACT_RESET: begin
            pos_in  = '0;
            step_in = spdb_pkg::DIR_NONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_raw_ff   <= 1'b0;
         stop_stamp_ff <= '0;
         flags_ff      <= '0;
      end else begin
         if (do_sample) begin
            stop_raw_ff   <= stop_raw_in;
            stop_stamp_ff <= stop_stamp_in;
         end
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         armed_ff  <= armed_in;
         lights_ff <= lights_in;
         stop_ff   <= stop_in;
         button_ff <= button_in;
         pos_ff    <= pos_in;
         step_ff   <= step_in;
         rflags_ff <= rflags_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_armed          = armed_ff;
   assign rsp_lights_on      = lights_ff;
   assign rsp_stop_active    = stop_ff;
   assign rsp_button_down    = button_ff;
   assign rsp_position       = pos_ff;
   assign rsp_last_step      = step_ff;
   assign rsp_stop_seen      = rflags_ff[spdb_pkg::FLAG_STOP];
   assign rsp_arm_toggled    = rflags_ff[spdb_pkg::FLAG_ARM];
   assign rsp_lights_toggled = rflags_ff[spdb_pkg::FLAG_LIGHTS];
   assign rsp_button_hit     = rflags_ff[spdb_pkg::FLAG_BUTTON];

endmodule

`default_nettype wire
